/* rtl/tgst_pkg.sv */
package tgst_pkg;

    // fraction bits of the speed result
    localparam int unsigned SPEED_FRAC_BITS = 16;

    // distance in mm is scaled by this to reach um-per-us (m/s) units
    localparam int unsigned DIST_W  = 16;
    localparam int unsigned SCALE_W = 10;
    localparam logic [SCALE_W-1:0] SPEED_SCALE = SCALE_W'(1000);
    localparam int unsigned PROD_W  = DIST_W + SCALE_W;
    localparam int unsigned NUM_W   = PROD_W + SPEED_FRAC_BITS;
    localparam int unsigned CNT_W   = $clog2(NUM_W + 1);

    // item kinds
    localparam logic [1:0] KIND_GATE  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_REARM = 2'd2;

    // phase codes reported in status
    localparam logic [1:0] PH_ARMED   = 2'd0;
    localparam logic [1:0] PH_WAIT    = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;
    localparam logic [1:0] PH_TIMEOUT = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_MIN_TRAVEL = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT    = 2'd1;
    localparam logic [1:0] CFG_DISTANCE   = 2'd2;
    localparam logic [1:0] CFG_ACTIVE_LOW = 2'd3;

    localparam logic GATE_A = 1'b0;
    localparam logic GATE_B = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic        gate_id;
        logic        pin_level;
        logic [31:0] now_us;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        first_gate;
        logic        second_gate;
        logic [31:0] elapsed_us;
        logic [31:0] speed_q16;
        logic        result_valid;
    } t_out_item;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* rtl/two_gate_speed_trap_top.sv */
// Two-gate speed trap.
// Input channel i_in (valid/stall) carries gate edges, time ticks and rearm
// commands; every accepted item yields exactly one status item on o_out.
// Configuration is written through i_cfg_* (valid/ready, always ready) at
// register indexes 0 min travel, 1 timeout, 2 gate distance, 3 active low.
// An item that does not finish a timing reaches the output register in the
// cycle after its transfer. An item that finishes a timing with nonzero
// elapsed time runs the speed division: one restoring step per cycle over the
// 42-bit numerator; its result is loaded into the output register once the
// divider is done and the output register is free.
// Throughput: one item per cycle without a division while o_out is not
// stalled; the block takes no new item while the divider runs.
// A finished result waits in the output register while o_out is stalled, and
// the input stalls until that result is taken.
// Reset (synchronous, active low) restores the registers to their defaults
// and the trap to armed with all measurements cleared.
module two_gate_speed_trap_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tgst_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tgst_pkg::t_out_item  o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import tgst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [31:0]       r_min_travel;
    logic [31:0]       r_timeout;
    logic [DIST_W-1:0] r_distance;
    logic              r_active_low;

    // trap state
    logic [1:0]  r_phase, n_phase;
    logic        r_start_gate, n_start_gate;
    logic        r_stop_gate, n_stop_gate;
    logic [31:0] r_start_time, n_start_time;
    logic [31:0] r_measured, n_measured;
    logic [31:0] r_speed, n_speed;

    // output register
    t_out_item r_out;
    logic      r_out_valid;

    logic        out_free;
    logic        in_xfer;
    logic        start_div;
    logic        div_load;
    logic [31:0] gap;
    logic [31:0] limit;
    logic        gap_ok;
    logic        active;
    t_div_stat   div_stat;
    logic [31:0] div_quot;
    t_out_item   item_out;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || !out_free;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign div_load    = (r_state == S_DIV) && div_stat.done && out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // shared elapsed-time subtract and compare
    assign gap    = i_in.now_us - r_start_time;
    assign limit  = (i_in.kind == KIND_TICK) ? r_timeout : r_min_travel;
    assign gap_ok = gap >= limit;
    assign active = i_in.pin_level ^ r_active_low;

    // trap next state for the item on the input
    always_comb begin
        n_phase      = r_phase;
        n_start_gate = r_start_gate;
        n_stop_gate  = r_stop_gate;
        n_start_time = r_start_time;
        n_measured   = r_measured;
        n_speed      = r_speed;
        start_div    = 1'b0;
        case (i_in.kind)
            KIND_GATE: begin
                if (active) begin
                    if (r_phase == PH_ARMED) begin
                        n_start_gate = i_in.gate_id;
                        n_start_time = i_in.now_us;
                        n_phase      = PH_WAIT;
                    end else if (r_phase == PH_WAIT && i_in.gate_id != r_start_gate
                                 && gap_ok) begin
                        n_stop_gate = i_in.gate_id;
                        n_measured  = gap;
                        n_speed     = '0;
                        n_phase     = PH_DONE;
                        start_div   = (gap != 32'd0);
                    end
                end
            end
            KIND_TICK: begin
                if (r_phase == PH_WAIT && gap_ok) n_phase = PH_TIMEOUT;
            end
            KIND_REARM: begin
                n_phase      = PH_ARMED;
                n_start_gate = GATE_A;
                n_stop_gate  = GATE_B;
                n_start_time = '0;
                n_measured   = '0;
                n_speed      = '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        item_out.status       = n_phase;
        item_out.first_gate   = n_start_gate;
        item_out.second_gate  = n_stop_gate;
        item_out.elapsed_us   = n_measured;
        item_out.speed_q16    = n_speed;
        item_out.result_valid = (n_phase == PH_DONE) && (n_measured != 32'd0);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_xfer && start_div) n_state = S_DIV;
            S_DIV:  if (div_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    tgst_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_xfer && start_div),
        .i_dist    (r_distance),
        .i_divisor (gap),
        .o_stat    (div_stat),
        .o_quot    (div_quot)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_travel <= 32'd1000;
            r_timeout    <= 32'd2000000;
            r_distance   <= DIST_W'(300);
            r_active_low <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MIN_TRAVEL: r_min_travel <= i_cfg_data;
                CFG_TIMEOUT:    r_timeout    <= i_cfg_data;
                CFG_DISTANCE:   r_distance   <= i_cfg_data[DIST_W-1:0];
                CFG_ACTIVE_LOW: r_active_low <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // trap state: advance on transfer, store speed when the division ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_ARMED;
            r_start_gate <= GATE_A;
            r_stop_gate  <= GATE_B;
            r_start_time <= '0;
            r_measured   <= '0;
            r_speed      <= '0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_phase      <= n_phase;
                r_start_gate <= n_start_gate;
                r_stop_gate  <= n_stop_gate;
                r_start_time <= n_start_time;
                r_measured   <= n_measured;
                r_speed      <= n_speed;
            end else if (div_load) begin
                r_speed <= div_quot;
            end
        end
    end

    // output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer && !start_div) begin
            r_out_valid <= 1'b1;
        end else if (div_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && !start_div) begin
            r_out <= item_out;
        end else if (div_load) begin
            r_out.status       <= PH_DONE;
            r_out.first_gate   <= r_start_gate;
            r_out.second_gate  <= r_stop_gate;
            r_out.elapsed_us   <= r_measured;
            r_out.speed_q16    <= div_quot;
            r_out.result_valid <= 1'b1;
        end
    end

endmodule

/* rtl/tgst_div.sv */
module tgst_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tgst_pkg::DIST_W-1:0] i_dist,
    input  logic [31:0]                 i_divisor,
    output tgst_pkg::t_div_stat         o_stat,
    output logic [31:0]                 o_quot
);
    import tgst_pkg::*;

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_DONE = 3'b100
    } t_dstate;

    t_dstate          r_state, n_state;
    logic [NUM_W-1:0] r_num;
    logic [31:0]      r_rem;
    logic [31:0]      r_divisor;
    logic [CNT_W-1:0] r_cnt;

    logic [PROD_W-1:0] prod;
    logic [32:0]       rem_sh;
    logic [32:0]       rem_sub;
    logic              rem_ge;
    logic [NUM_W+31:0] quot_x;

    // scale distance to the numerator
    assign prod = PROD_W'(i_dist) * PROD_W'(SPEED_SCALE);

    // one restoring step: bring down the next numerator bit
    assign rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_divisor};
    assign rem_sub = rem_sh - {1'b0, r_divisor};

    // saturate the quotient to 32 bits
    assign quot_x = {32'b0, r_num};
    assign o_quot = (|quot_x[NUM_W+31:32]) ? 32'hFFFF_FFFF : quot_x[31:0];

    assign o_stat.busy = (r_state == D_RUN);
    assign o_stat.done = (r_state == D_DONE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE: if (i_start) n_state = D_RUN;
            D_RUN:  if (r_cnt == CNT_W'(1)) n_state = D_DONE;
            D_DONE: if (i_start) n_state = D_RUN;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // load operands, then shift one quotient bit in per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num     <= NUM_W'(prod) << SPEED_FRAC_BITS;
            r_rem     <= '0;
            r_divisor <= i_divisor;
            r_cnt     <= CNT_W'(NUM_W);
        end else if (r_state == D_RUN) begin
            r_num <= {r_num[NUM_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

endmodule

/* rtl/tgst_chk.sv */
module tgst_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input tgst_pkg::t_out_item o_out
);
    import tgst_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("result changed while stalled");

    // result_valid only for a completed, nonzero timing
    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.result_valid |->
            o_out.status == PH_DONE && o_out.elapsed_us != 32'd0)
        else $error("result_valid without completed timing");

    // speed is only reported after a completion
    a_speed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != PH_DONE |-> o_out.speed_q16 == 32'd0)
        else $error("speed reported outside completion");

    // a waiting result blocks the input until it is taken
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while output register is held");

endmodule

bind two_gate_speed_trap_top tgst_chk u_tgst_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
